### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the CAN transport block.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/ctsr_pkg.sv
// Package of the CAN transport segmenter/reassembler: constants and types.
// Depends on nothing.
`default_nettype none
package ctsr_pkg;
  localparam int BUF_BYTES_DEF = 256;
  localparam logic [10:0] CAN_ID_RST = 11'h7E8;
  localparam logic [7:0] PAD_RST = 8'hAA;
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_TXBYTE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_READY = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [3:0] PCI_SF = 4'd0;
  localparam logic [3:0] PCI_FF = 4'd1;
  localparam logic [3:0] PCI_CF = 4'd2;
  localparam logic [3:0] PCI_FC = 4'd3;
  localparam logic CFG_CAN_ID = 1'b0;
  localparam logic CFG_PAD = 1'b1;
endpackage
`default_nettype wire

### rtl/can_transport_segmenter_reassembler.sv
// CAN transport layer (simplified ISO-TP): one byte per cycle moves between a shift register
// (eight bytes on receive, seven data bytes on send) and the byte-wide rx/tx stores.
// A request is accepted only while idle. A received frame is written into the rx store a byte
// at a time, a read waits on the registered store, and a sent frame is read from the tx store
// into its slots; a flow control sends every remaining consecutive frame before going idle.
// Reset (synchronous, active low) resets counters and registers to their defaults; the stores are not cleared.
`default_nettype none
module can_transport_segmenter_reassembler
  import ctsr_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_frame_bytes,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic        in_payload_last,
  input  wire logic [7:0]  in_read_index,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [10:0]      out_can_id,
  output logic [63:0]      out_frame,
  output logic [11:0]      message_length,
  output logic [7:0]       read_data,
  output logic             last_of_run
);
  localparam int AW = $clog2(BUF_BYTES);
  localparam logic [11:0] BUFN = 12'(BUF_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RXW  = 3'd1;  // write frame bytes into rx store
  localparam logic [2:0] S_RD   = 3'd2;  // read wait
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_TXR  = 3'd4;  // read tx store into frame shift
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [1:0] R_NONE  = 2'd0;
  localparam logic [1:0] R_READY = 2'd1;
  localparam logic [1:0] R_FC    = 2'd2;

  logic [2:0]  st_r;
  logic [10:0] id_r;
  logic [7:0]  pad_r;
  logic [11:0] rx_total_r, rx_count_r, tx_loaded_r, tx_total_r, tx_sent_r;
  logic [3:0]  rx_seq_r, tx_seq_r;
  logic [63:0] sh_r;       // received bytes, shifted left one byte a step
  logic [55:0] dsh_r;      // data bytes of a sent frame, shifted in from the right
  logic [15:0] hdr_r;      // header bytes of a sent frame
  logic [3:0]  cnt_r;      // rx: bytes left to write; tx: bytes to take from the store
  logic [2:0]  i_r;        // tx: read slot being issued
  logic [2:0]  slot_r;     // tx: data slots of the frame
  logic [11:0] ptr_r;      // store address
  logic        is_cf_r;    // current tx transfer is consecutive frames
  logic        is_ff_r;    // current tx frame is a first frame
  logic        da_r;       // the read issued last cycle fills a slot
  logic        dv_r;       // and carries a store byte rather than padding
  logic [11:0] rdlen_r;
  logic [1:0]  res_r;

  // Store ports.
  logic          rx_we, tx_we;
  logic [AW-1:0] rx_a, tx_a;
  logic [7:0]    rx_wd, tx_wd, rx_q, tx_q;

  ctsr_ram #(.DEPTH(BUF_BYTES), .AW(AW)) u_rx (
    .clk(clk), .we(rx_we), .addr(rx_a), .wdata(rx_wd), .rdata(rx_q));
  ctsr_ram #(.DEPTH(BUF_BYTES), .AW(AW)) u_tx (
    .clk(clk), .we(tx_we), .addr(tx_a), .wdata(tx_wd), .rdata(tx_q));

  assign busy = (st_r != S_IDLE);
  wire accept = start && !busy;
  wire [7:0] b0 = in_frame_bytes[63:56];
  wire [11:0] ff_len = {b0[3:0], in_frame_bytes[55:48]};
  wire [11:0] rx_left = rx_total_r - rx_count_r;
  wire [3:0] rx_take = (rx_left >= 12'd7) ? 4'd7 : rx_left[3:0];
  wire [11:0] rx_nc = rx_count_r + {8'd0, rx_take};
  wire [11:0] tx_left = tx_total_r - tx_sent_r;
  wire [3:0] tx_take = (tx_left >= 12'd7) ? 4'd7 : tx_left[3:0];
  wire [11:0] tx_len = (tx_loaded_r < BUFN) ? tx_loaded_r + 12'd1 : tx_loaded_r;

  assign rx_we = (st_r == S_RXW) && (cnt_r != 4'd0) && (ptr_r < BUFN);
  assign rx_a  = ptr_r[AW-1:0];
  assign rx_wd = sh_r[63:56];
  assign tx_we = accept && (in_req_type == REQ_TXBYTE) && (tx_loaded_r < BUFN);
  assign tx_a  = tx_we ? tx_loaded_r[AW-1:0] : ptr_r[AW-1:0];
  assign tx_wd = in_payload_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      id_r <= CAN_ID_RST;
      pad_r <= PAD_RST;
      rx_total_r <= '0; rx_count_r <= '0; rx_seq_r <= 4'd1;
      tx_loaded_r <= '0; tx_total_r <= '0; tx_sent_r <= '0; tx_seq_r <= 4'd1;
      sh_r <= '0; dsh_r <= '0; hdr_r <= '0;
      cnt_r <= '0; i_r <= '0; slot_r <= '0; ptr_r <= '0;
      is_cf_r <= 1'b0; is_ff_r <= 1'b0; da_r <= 1'b0; dv_r <= 1'b0;
      rdlen_r <= '0; res_r <= R_NONE;
      out_valid <= 1'b0; out_kind <= KIND_FRAME; out_can_id <= '0;
      out_frame <= '0; message_length <= '0; read_data <= '0; last_of_run <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      da_r <= (st_r == S_TXR) && (i_r < slot_r);
      dv_r <= ({1'b0, i_r} < cnt_r);
      if (cfg_we) begin
        if (cfg_index == CFG_CAN_ID) id_r <= cfg_data;
        else pad_r <= cfg_data[7:0];
      end
      case (st_r)
        S_IDLE: begin
          if (accept) begin
            case (in_req_type)
              REQ_FRAME: begin
                case (b0[7:4])
                  PCI_SF: begin
                    if (b0[3:0] >= 4'd1 && b0[3:0] <= 4'd7) begin
                      sh_r <= in_frame_bytes << 8;
                      ptr_r <= '0; cnt_r <= b0[3:0];
                      res_r <= R_READY; rdlen_r <= {8'd0, b0[3:0]};
                      st_r <= S_RXW;
                    end
                  end
                  PCI_FF: begin
                    if (ff_len > 12'd7 && ff_len <= BUFN) begin
                      sh_r <= in_frame_bytes << 16;
                      ptr_r <= '0; cnt_r <= 4'd6;
                      rx_total_r <= ff_len; rx_count_r <= 12'd6; rx_seq_r <= 4'd1;
                      res_r <= R_FC;
                      st_r <= S_RXW;
                    end else begin
                      rx_total_r <= '0; rx_count_r <= '0;
                    end
                  end
                  PCI_CF: begin
                    if (rx_total_r != 12'd0) begin
                      if (b0[3:0] == rx_seq_r) begin
                        sh_r <= in_frame_bytes << 8;
                        ptr_r <= rx_count_r; cnt_r <= rx_take;
                        rx_seq_r <= rx_seq_r + 4'd1;
                        if (rx_nc >= rx_total_r) begin
                          res_r <= R_READY; rdlen_r <= rx_total_r;
                          rx_total_r <= '0; rx_count_r <= '0;
                        end else begin
                          res_r <= R_NONE;
                          rx_count_r <= rx_nc;
                        end
                        st_r <= S_RXW;
                      end else begin
                        rx_total_r <= '0; rx_count_r <= '0;
                      end
                    end
                  end
                  PCI_FC: begin
                    if (tx_sent_r < tx_total_r) begin
                      is_cf_r <= 1'b1; is_ff_r <= 1'b0;
                      hdr_r <= {PCI_CF, tx_seq_r, 8'd0};
                      tx_seq_r <= tx_seq_r + 4'd1;
                      ptr_r <= tx_sent_r; cnt_r <= tx_take;
                      tx_sent_r <= tx_sent_r + {8'd0, tx_take};
                      slot_r <= 3'd7; i_r <= '0;
                      st_r <= S_TXR;
                    end
                  end
                  default: ;
                endcase
              end
              REQ_TXBYTE: begin
                if (in_payload_last) begin
                  tx_loaded_r <= '0;
                  is_cf_r <= 1'b0;
                  ptr_r <= '0; i_r <= '0;
                  if (tx_len <= 12'd7) begin
                    is_ff_r <= 1'b0;
                    hdr_r <= {PCI_SF, tx_len[3:0], 8'd0};
                    cnt_r <= tx_len[3:0]; slot_r <= 3'd7;
                  end else begin
                    is_ff_r <= 1'b1;
                    hdr_r <= {PCI_FF, tx_len};
                    cnt_r <= 4'd6; slot_r <= 3'd6;
                    tx_total_r <= tx_len; tx_sent_r <= 12'd6; tx_seq_r <= 4'd1;
                  end
                  st_r <= S_TXR;
                end else begin
                  tx_loaded_r <= tx_len;
                end
              end
              REQ_READ: begin
                ptr_r <= {4'd0, in_read_index};
                st_r <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RXW: begin
          if (cnt_r != 4'd0) begin
            sh_r <= sh_r << 8;
            ptr_r <= ptr_r + 12'd1;
            cnt_r <= cnt_r - 4'd1;
          end else begin
            case (res_r)
              R_READY: begin
                out_valid <= 1'b1; out_kind <= KIND_READY; out_can_id <= '0;
                out_frame <= '0; message_length <= rdlen_r; read_data <= '0;
                last_of_run <= 1'b1;
              end
              R_FC: begin
                out_valid <= 1'b1; out_kind <= KIND_FRAME; out_can_id <= id_r;
                out_frame <= {PCI_FC, 4'd0, 16'd0, {5{pad_r}}};
                message_length <= '0; read_data <= '0;
                last_of_run <= 1'b1;
              end
              default: ;
            endcase
            st_r <= S_IDLE;
          end
        end
        S_RD: st_r <= S_RD2;
        S_RD2: begin
          out_valid <= 1'b1; out_kind <= KIND_READ; out_can_id <= '0;
          out_frame <= '0; message_length <= '0;
          read_data <= (ptr_r < BUFN) ? rx_q : 8'd0;
          last_of_run <= 1'b1;
          st_r <= S_IDLE;
        end
        S_TXR: begin
          // Store data arrives the cycle after its address; slots past the byte count get padding.
          ptr_r <= ptr_r + 12'd1;
          i_r <= i_r + 3'd1;
          if (da_r) dsh_r <= {dsh_r[47:0], dv_r ? tx_q : pad_r};
          if (i_r == slot_r) st_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid <= 1'b1; out_kind <= KIND_FRAME; out_can_id <= id_r;
          out_frame <= is_ff_r ? {hdr_r, dsh_r[47:0]} : {hdr_r[15:8], dsh_r};
          message_length <= '0; read_data <= '0;
          if (is_cf_r && tx_sent_r < tx_total_r) begin
            last_of_run <= 1'b0;
            hdr_r <= {PCI_CF, tx_seq_r, 8'd0};
            tx_seq_r <= tx_seq_r + 4'd1;
            ptr_r <= tx_sent_r; cnt_r <= tx_take;
            tx_sent_r <= tx_sent_r + {8'd0, tx_take};
            i_r <= '0;
            st_r <= S_TXR;
          end else begin
            last_of_run <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_out_one, clk, rst_n, out_valid, $past(busy))
  `ASSERT_NEXT(a_start_busy, clk, rst_n, accept && in_req_type == REQ_READ, busy)
  `ASSERT_IMPL(a_cnt, clk, rst_n, st_r == S_RXW, cnt_r <= 4'd7)
  `ASSERT_IMPL(a_tx_sent, clk, rst_n, st_r == S_IDLE, tx_sent_r <= tx_total_r)
endmodule
`default_nettype wire

### rtl/ctsr_ram.sv
// Byte-wide single-port store with registered read.
// Depends on nothing.
`default_nettype none
module ctsr_ram #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sim/ctsr_checker.sv
// Checker for the CAN transport segmenter/reassembler: watches both channels,
// predicts every result beat and compares it field by field. Uses ctsr_pkg.
`timescale 1ns / 1ps
module ctsr_checker
  import ctsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_frame_bytes,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic        in_payload_last,
  input  wire logic [7:0]  in_read_index,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        out_valid,
  input  wire logic [1:0]  out_kind,
  input  wire logic [10:0] out_can_id,
  input  wire logic [63:0] out_frame,
  input  wire logic [11:0] message_length,
  input  wire logic [7:0]  read_data,
  input  wire logic        last_of_run,
  output int               fail_count,
  output int               pending
);

  localparam int BUF = BUF_BYTES_DEF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] can_id;
    logic [63:0] frame;
    logic [11:0] length;
    logic [7:0]  data;
    logic        last;
  } ctsr_beat_t;

  ctsr_beat_t  expected_q[$];
  logic [7:0]  rx_mem[BUF];
  logic [7:0]  tx_mem[BUF];
  logic [11:0] rx_total, rx_count, tx_loaded, tx_total, tx_sent;
  logic [3:0]  rx_seq, tx_seq;
  logic [10:0] resp_id;
  logic [7:0]  pad;

  assign pending = expected_q.size();

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push(input logic [1:0] kind, input logic [63:0] frame,
                      input logic [11:0] length, input logic [7:0] data);
    ctsr_beat_t b;
    b.kind = kind;
    b.can_id = (kind == KIND_FRAME) ? resp_id : 11'd0;
    b.frame = frame;
    b.length = length;
    b.data = data;
    b.last = 1'b0;
    expected_q.push_back(b);
  endtask

  function automatic logic [7:0] fbyte(input logic [63:0] f, input int i);
    return f[63-8*i -: 8];
  endfunction

  task automatic predict_frame(input logic [63:0] f);
    logic [7:0]  b0;
    logic [63:0] fr;
    logic [11:0] total, take;
    int n;
    b0 = fbyte(f, 0);
    case (b0[7:4])
      PCI_SF: begin
        if (b0[3:0] >= 1 && b0[3:0] <= 7) begin
          for (int i = 0; i < b0[3:0]; i++) rx_mem[i] = fbyte(f, 1 + i);
          push(KIND_READY, 64'd0, {8'd0, b0[3:0]}, 8'd0);
        end
      end
      PCI_FF: begin
        total = {b0[3:0], fbyte(f, 1)};
        if (total > 7 && total <= BUF) begin
          for (int i = 0; i < 6; i++) rx_mem[i] = fbyte(f, 2 + i);
          rx_total = total;
          rx_count = 12'd6;
          rx_seq = 4'd1;
          fr = {8{pad}};
          fr[63:40] = 24'h300000;
          push(KIND_FRAME, fr, 12'd0, 8'd0);
        end else begin
          rx_total = '0;
          rx_count = '0;
        end
      end
      PCI_CF: begin
        if (rx_total != 0) begin
          if (b0[3:0] == rx_seq) begin
            take = (rx_total - rx_count >= 7) ? 12'd7 : rx_total - rx_count;
            for (int i = 0; i < take && rx_count < BUF; i++) begin
              rx_mem[rx_count] = fbyte(f, 1 + i);
              rx_count++;
            end
            rx_seq++;
            if (rx_count >= rx_total) begin
              push(KIND_READY, 64'd0, rx_total, 8'd0);
              rx_total = '0;
              rx_count = '0;
            end
          end else begin
            rx_total = '0;
            rx_count = '0;
          end
        end
      end
      PCI_FC: begin
        n = 0;
        while (tx_sent < tx_total && n < 64) begin
          take = (tx_total - tx_sent >= 7) ? 12'd7 : tx_total - tx_sent;
          fr = {8{pad}};
          fr[63:56] = {4'h2, tx_seq};
          for (int i = 0; i < take; i++) begin
            fr[55-8*i -: 8] = tx_mem[tx_sent];
            tx_sent++;
          end
          push(KIND_FRAME, fr, 12'd0, 8'd0);
          tx_seq++;
          n++;
        end
        tx_sent = tx_total;
      end
      default: ;
    endcase
  endtask

  task automatic predict_tx(input logic [7:0] b, input logic last);
    logic [11:0] len;
    logic [63:0] fr;
    if (tx_loaded < BUF) begin
      tx_mem[tx_loaded] = b;
      tx_loaded++;
    end
    if (last) begin
      len = tx_loaded;
      tx_loaded = '0;
      fr = {8{pad}};
      if (len <= 7) begin
        fr[63:56] = len[7:0];
        for (int i = 0; i < len; i++) fr[55-8*i -: 8] = tx_mem[i];
      end else begin
        fr[63:56] = {4'h1, len[11:8]};
        fr[55:48] = len[7:0];
        for (int i = 0; i < 6; i++) fr[47-8*i -: 8] = tx_mem[i];
        tx_total = len;
        tx_sent = 12'd6;
        tx_seq = 4'd1;
      end
      push(KIND_FRAME, fr, 12'd0, 8'd0);
    end
  endtask

  always @(posedge clk) begin
    int n_prior;
    ctsr_beat_t e;
    if (!rst_n) begin
      rx_total = '0; rx_count = '0; rx_seq = 4'd1;
      tx_loaded = '0; tx_total = '0; tx_sent = '0; tx_seq = 4'd1;
      resp_id = CAN_ID_RST;
      pad = PAD_RST;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CAN_ID) resp_id = cfg_data;
        else pad = cfg_data[7:0];
      end
      // Results of one beat are judged against expectations queued earlier,
      // so the comparison comes ahead of the new prediction.
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d frame %h", out_kind, out_frame));
        end else begin
          e = expected_q.pop_front();
          if (out_kind !== e.kind)
            report($sformatf("kind %0d, expected %0d", out_kind, e.kind));
          if (out_can_id !== e.can_id)
            report($sformatf("can_id %h, expected %h", out_can_id, e.can_id));
          if (out_frame !== e.frame)
            report($sformatf("frame %h, expected %h", out_frame, e.frame));
          if (message_length !== e.length)
            report($sformatf("length %0d, expected %0d", message_length, e.length));
          if (read_data !== e.data)
            report($sformatf("read_data %h, expected %h", read_data, e.data));
          if (last_of_run !== e.last)
            report($sformatf("last_of_run %b, expected %b", last_of_run, e.last));
        end
      end
      if (start && !busy) begin
        n_prior = expected_q.size();
        case (in_req_type)
          REQ_FRAME: predict_frame(in_frame_bytes);
          REQ_TXBYTE: predict_tx(in_payload_byte, in_payload_last);
          REQ_READ: push(KIND_READ, 64'd0, 12'd0, rx_mem[in_read_index]);
          default: ;
        endcase
        if (expected_q.size() > n_prior) expected_q[expected_q.size() - 1].last = 1'b1;
      end
    end
  end

endmodule

### sim/tb.sv
// Top of the testbench: clock, reset, stimulus and verdict for the CAN
// transport block. Depends on ctsr_pkg, the block and ctsr_checker.
`timescale 1ns / 1ps
module tb;
  import ctsr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_req_type = REQ_READ;
  logic [63:0] in_frame_bytes = '0;
  logic [7:0]  in_payload_byte = '0;
  logic        in_payload_last = 1'b0;
  logic [7:0]  in_read_index = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_CAN_ID;
  logic [10:0] cfg_data = '0;
  wire         busy, out_valid, last_of_run;
  wire [1:0]   out_kind;
  wire [10:0]  out_can_id;
  wire [63:0]  out_frame;
  wire [11:0]  message_length;
  wire [7:0]   read_data;
  int          fail_count, pending;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  bit          no_gaps = 0;

  always #6 clk = ~clk;

  can_transport_segmenter_reassembler dut (.*);
  ctsr_checker checker_i (.*);

  // A run of cycles with no beat on either side means the block is stuck.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] rt, input logic [63:0] fb,
                      input logic [7:0] pb, input logic pl, input logic [7:0] ri);
    int r, gap;
    start <= 1'b1;
    in_req_type <= rt;
    in_frame_bytes <= fb;
    in_payload_byte <= pb;
    in_payload_last <= pl;
    in_read_index <= ri;
    do @(posedge clk); while (busy);
    items_sent++;
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                             : $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_frame(input logic [63:0] f);
    send(REQ_FRAME, f, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_read(input logic [7:0] idx);
    send(REQ_READ, rand64(), 8'($urandom), 1'($urandom), idx);
  endtask

  // Received message: a single frame, or a first frame and its consecutive
  // frames; a broken one gets a wrong sequence number at a random frame.
  task automatic rx_message(input int len, input bit broken);
    int ncf, bad_at;
    logic [3:0] seq;
    logic [63:0] f;
    if (len <= 7) begin
      f = rand64();
      f[63:56] = {PCI_SF, 4'(len)};
      send_frame(f);
    end else begin
      f = rand64();
      f[63:48] = {PCI_FF, 12'(len)};
      send_frame(f);
      ncf = (len - 6 + 6) / 7;
      bad_at = broken ? $urandom_range(0, ncf - 1) : -1;
      seq = 4'd1;
      for (int i = 0; i < ncf; i++) begin
        f = rand64();
        f[63:56] = {PCI_CF, (i == bad_at) ? seq + 4'($urandom_range(1, 15)) : seq};
        send_frame(f);
        seq++;
      end
    end
  endtask

  task automatic flow_control();
    logic [63:0] f;
    f = rand64();
    f[63:60] = PCI_FC;
    send_frame(f);
  endtask

  task automatic tx_message(input int len, input bit with_fc);
    for (int i = 0; i < len; i++)
      send(REQ_TXBYTE, rand64(), 8'($urandom), i == len - 1, 8'($urandom));
    if (with_fc && len > 7) flow_control();
  endtask

  task automatic settle_and_configure(input logic [10:0] id, input logic [7:0] pb);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CAN_ID;
    cfg_data <= id;
    @(posedge clk);
    cfg_index <= CFG_PAD;
    cfg_data <= {3'd0, pb};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r, len;
    logic [63:0] f;
    r = $urandom_range(0, 99);
    no_gaps = ($urandom_range(0, 3) == 0);
    if (r < 30) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7)
          : ($urandom_range(0, 15) == 0) ? $urandom_range(200, 256) : $urandom_range(8, 40);
      rx_message(len, $urandom_range(0, 4) == 0);
    end else if (r < 60) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 270) : $urandom_range(1, 40);
      tx_message(len, $urandom_range(0, 6) != 0);
    end else if (r < 75) begin
      send_read(8'($urandom));
    end else if (r < 85) begin
      if ($urandom_range(0, 1)) flow_control();
      else begin
        f = rand64();
        f[63:60] = PCI_CF;
        send_frame(f);
      end
    end else begin
      send(2'($urandom_range(0, 3)), rand64(), 8'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [63:0] f;
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Fill the whole reassembly store first so that any read index is legal;
    // its 36 consecutive frames also wrap the sequence number.
    rx_message(256, 0);
    // Directed part.
    no_gaps = 1;
    rx_message(1, 0);
    rx_message(7, 0);
    send_frame(64'h00FF_FFFF_FFFF_FFFF);       // single frame, length zero
    send_frame(64'h08FF_FFFF_FFFF_FFFF);       // single frame, length eight
    send_frame(64'h1007_0102_0304_0506);       // first frame too short
    send_frame(64'h1101_0102_0304_0506);       // first frame too long
    rx_message(8, 0);
    send_frame(64'h2100_0000_0000_0000);       // consecutive frame with nothing open
    rx_message(20, 1);
    send_frame(64'h4FFF_FFFF_FFFF_FFFF);       // unknown frame type
    send_frame(64'hF000_0000_0000_0000);
    flow_control();                            // nothing pending
    tx_message(1, 0);
    tx_message(7, 0);
    tx_message(8, 1);
    send_read(8'd0);
    send_read(8'd255);
    send(2'd3, rand64(), 8'hFF, 1'b1, 8'hFF);  // unknown request
    send(REQ_TXBYTE, 64'd0, 8'h00, 1'b1, 8'h00);
    no_gaps = 0;
    target = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: settle_and_configure(11'd0, 8'd0);
        1: settle_and_configure(11'h7FF, 8'hFF);
        2: settle_and_configure(11'($urandom), 8'($urandom));
        default: settle_and_configure(CAN_ID_RST, PAD_RST);
      endcase
      target += 70;
      while (items_sent < target) random_item();
    end
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
